>>> hw/rtl/max_window_digit_product_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max window digit product block
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MAX_WINDOW_DIGIT_PRODUCT_ASSERT_SVH
`define MAX_WINDOW_DIGIT_PRODUCT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define MWDP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that an expression is never true outside reset
`define MWDP_NEVER(label, clk, rst, expr, msg) \
   `MWDP_ASSERT(label, clk, rst, !(expr), msg)
`else
`define MWDP_ASSERT(label, clk, rst, prop, msg)
`define MWDP_NEVER(label, clk, rst, expr, msg)
`endif

`endif

>>> hw/rtl/mwdp_pkg.sv
// ----------------------------------------------------------------------------
// mwdp_pkg
// Shared constants and types of the max window digit product block.
// ----------------------------------------------------------------------------
`default_nettype none

package mwdp_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int DIGIT_W    = 4;
   localparam int PRODUCT_W  = 51;
   localparam int LEN_W      = 5;
   localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int COUNT_W    = $clog2(MAX_WINDOW + 1);

   localparam logic [LEN_W-1:0]   DEFAULT_WINDOW = LEN_W'(13);
   localparam logic [DIGIT_W-1:0] MAX_DIGIT      = DIGIT_W'(9);

   typedef logic [PRODUCT_W-1:0] product_type;

   // Word handed from the cell row to the maximum tracker
   typedef struct packed {
      logic        last;
      logic        seen;
      product_type cand;
   } pipe_word_type;

endpackage

`default_nettype wire

>>> hw/rtl/mwdp_cell.sv
// ----------------------------------------------------------------------------
// mwdp_cell
// One cell of the trailing product row: holds the product of the most recent
// k+1 digits and multiplies its neighbor's product by each new digit.
// ----------------------------------------------------------------------------
`default_nettype none

module mwdp_cell (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 advance,
   input  wire  [mwdp_pkg::DIGIT_W-1:0]        digit,
   input  mwdp_pkg::product_type               prev_product,
   output mwdp_pkg::product_type               product,
   output mwdp_pkg::product_type               product_next
);
   import mwdp_pkg::*;

   logic [PRODUCT_W+DIGIT_W-1:0] full_product;
   product_type                  product_ff;
   product_type                  product_in;

   // Multiply and saturate at the product width
   always_comb begin
      full_product = {{DIGIT_W{1'b0}}, prev_product} * {{PRODUCT_W{1'b0}}, digit};
      if (|full_product[PRODUCT_W+DIGIT_W-1:PRODUCT_W]) begin
         product_in = {PRODUCT_W{1'b1}};
      end else begin
         product_in = full_product[PRODUCT_W-1:0];
      end
   end

   // Hold the product, advance on each new digit
   always_ff @(posedge clock) begin
      if (reset) begin
         product_ff <= '0;
      end else if (advance) begin
         product_ff <= product_in;
      end
   end

   assign product      = product_ff;
   assign product_next = product_in;

endmodule

`default_nettype wire

>>> hw/rtl/mwdp_best.sv
// ----------------------------------------------------------------------------
// mwdp_best
// Tracks the greatest window product of a series and holds the result word
// until the output side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mwdp_best (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     pipe_valid,
   input  mwdp_pkg::pipe_word_type pipe_word,
   output logic                    pipe_ready,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output mwdp_pkg::product_type   rsp_peak_product,
   output logic                    rsp_window_seen
);
   import mwdp_pkg::*;

   product_type best_ff, best_in;
   product_type max_product;
   logic        take;
   logic        rsp_valid_ff, rsp_valid_in;
   product_type rsp_product_ff, rsp_product_in;
   logic        rsp_seen_ff, rsp_seen_in;

   // Compare the candidate and retire the word; a last word needs a free slot
   always_comb begin
      max_product    = (pipe_word.cand > best_ff) ? pipe_word.cand : best_ff;
      pipe_ready     = !pipe_word.last || !rsp_valid_ff || rsp_ready;
      take           = pipe_valid && pipe_ready;
      best_in        = best_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_product_in = rsp_product_ff;
      rsp_seen_in    = rsp_seen_ff;
      if (take) begin
         if (pipe_word.last) begin
            best_in        = '0;
            rsp_valid_in   = 1'b1;
            rsp_product_in = max_product;
            rsp_seen_in    = pipe_word.seen;
         end else begin
            best_in = max_product;
         end
      end
   end

   // Hold best and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_product_ff <= rsp_product_in;
      rsp_seen_ff    <= rsp_seen_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_peak_product = rsp_product_ff;
   assign rsp_window_seen  = rsp_seen_ff;

endmodule

`default_nettype wire

>>> hw/rtl/max_window_digit_product.sv
// Result path: the last digit of a series is held in the pipe word register,
//   then its result word in the result register.
// Throughput: one digit per cycle; the row of 16 product cells and the max
//   tracker each take one word a cycle, and input stalls only while a
//   finished result waits behind another untaken result.
// Reset: clears the cells, digit count, best product and pending result;
//   window length returns to 13.
`default_nettype none

// ----------------------------------------------------------------------------
// max_window_digit_product
// Greatest product of adjacent decimal digits over a sliding window of
// configurable length, reported once per digit series.
// ----------------------------------------------------------------------------
module max_window_digit_product (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [mwdp_pkg::DIGIT_W-1:0]   req_digit,
   input  wire                            req_last_digit,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [mwdp_pkg::PRODUCT_W-1:0] rsp_peak_product,
   output logic                           rsp_window_seen,
   input  wire                            csr_wr_en,
   input  wire  [mwdp_pkg::LEN_W-1:0]     csr_wr_data
);
   import mwdp_pkg::*;

`include "max_window_digit_product_assert.svh"

   logic [LEN_W-1:0]   window_ff;
   logic [LEN_W-1:0]   eff_len;
   logic [IDX_W-1:0]   sel_idx;
   logic [DIGIT_W-1:0] digit_clamped;
   logic               accept;
   logic [COUNT_W-1:0] digits_seen_ff, digits_seen_in, count_next;
   logic               pipe_valid_ff, pipe_valid_in;
   pipe_word_type      pipe_word_ff, pipe_word_in;
   logic               pipe_ready;
   product_type        cell_prev [MAX_WINDOW];
   product_type        cell_prod [MAX_WINDOW];
   product_type        cell_next [MAX_WINDOW];

   // Window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= DEFAULT_WINDOW;
      end else if (csr_wr_en) begin
         window_ff <= csr_wr_data;
      end
   end

   // Clamp length and digit
   always_comb begin
      if (window_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (window_ff > LEN_W'(MAX_WINDOW)) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end else begin
         eff_len = window_ff;
      end
      sel_idx       = IDX_W'(eff_len - LEN_W'(1));
      digit_clamped = (req_digit > MAX_DIGIT) ? MAX_DIGIT : req_digit;
   end

   assign req_ready = !pipe_valid_ff || pipe_ready;
   assign accept    = req_valid && req_ready;

   // Row of product cells; the first multiplies by one
   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign cell_prev[k] = PRODUCT_W'(1);
      end else begin : g_link
         assign cell_prev[k] = cell_prod[k-1];
      end
      mwdp_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (accept),
         .digit        (digit_clamped),
         .prev_product (cell_prev[k]),
         .product      (cell_prod[k]),
         .product_next (cell_next[k])
      );
   end

   // Count digits, pick the window candidate, build the pipe word
   always_comb begin
      count_next     = (digits_seen_ff < COUNT_W'(MAX_WINDOW)) ?
                       COUNT_W'(digits_seen_ff + COUNT_W'(1)) : digits_seen_ff;
      digits_seen_in = digits_seen_ff;
      pipe_valid_in  = pipe_valid_ff && !pipe_ready;
      pipe_word_in   = pipe_word_ff;
      if (accept) begin
         digits_seen_in    = req_last_digit ? '0 : count_next;
         pipe_valid_in     = 1'b1;
         pipe_word_in.last = req_last_digit;
         pipe_word_in.seen = (COUNT_W'(eff_len) <= count_next);
         pipe_word_in.cand = pipe_word_in.seen ? cell_next[sel_idx] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_seen_ff <= '0;
         pipe_valid_ff  <= 1'b0;
      end else begin
         digits_seen_ff <= digits_seen_in;
         pipe_valid_ff  <= pipe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_word_ff <= pipe_word_in;
   end

   // Track the maximum and hold the result word
   mwdp_best u_best (
      .clock            (clock),
      .reset            (reset),
      .pipe_valid       (pipe_valid_ff),
      .pipe_word        (pipe_word_ff),
      .pipe_ready       (pipe_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_peak_product (rsp_peak_product),
      .rsp_window_seen  (rsp_window_seen)
   );

   // Checks
   `MWDP_NEVER(a_count_range, clock, reset, digits_seen_ff > COUNT_W'(MAX_WINDOW), "digit count overran")
   `MWDP_ASSERT(a_last_clears, clock, reset, accept && req_last_digit |=> digits_seen_ff == '0, "series not cleared")
   `MWDP_ASSERT(a_rsp_from_last, clock, reset, $rose(rsp_valid) |-> $past(pipe_valid_ff && pipe_word_ff.last), "result without last digit")
   `MWDP_ASSERT(a_cand_needs_window, clock, reset, pipe_valid_ff && !pipe_word_ff.seen |-> pipe_word_ff.cand == '0, "candidate from partial window")

endmodule

`default_nettype wire
